// ===== design/smau_pkg.sv =====
// Shared types and constants for the small matrix arithmetic unit.
package smau_pkg;

    // index and dimension widths (MAX_DIM up to 16)
    localparam int IW     = 4;
    localparam int NW     = 5;
    localparam int DATA_W = 32;

    // item modes
    localparam logic [1:0] MODE_WR_A = 2'd0;
    localparam logic [1:0] MODE_WR_B = 2'd1;
    localparam logic [1:0] MODE_RUN  = 2'd2;

    // operations
    localparam logic [2:0] OP_PROD  = 3'd0;
    localparam logic [2:0] OP_SUM   = 3'd1;
    localparam logic [2:0] OP_DIFF  = 3'd2;
    localparam logic [2:0] OP_SCALE = 3'd3;
    localparam logic [2:0] OP_DIV   = 3'd4;
    localparam logic [2:0] OP_TRANS = 3'd5;

    // result status codes
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_SAT   = 2'd1;
    localparam logic [1:0] ST_SHAPE = 2'd2;
    localparam logic [1:0] ST_DIVZ  = 2'd3;

    // configuration register indexes
    localparam logic [1:0] CFG_A_ROWS = 2'd0;
    localparam logic [1:0] CFG_A_COLS = 2'd1;
    localparam logic [1:0] CFG_B_ROWS = 2'd2;
    localparam logic [1:0] CFG_B_COLS = 2'd3;

    typedef struct packed {
        logic [1:0]         mode;
        logic [2:0]         op;
        logic [2:0]         row_index;
        logic [2:0]         col_index;
        logic signed [31:0] value;
    } t_in_item;

    typedef struct packed {
        logic [2:0]         out_row;
        logic [2:0]         out_col;
        logic signed [31:0] result;
        logic               last;
        logic [1:0]         status;
    } t_out_item;

    // controller to datapath commands
    typedef struct packed {
        logic          wr_a;
        logic          wr_b;
        logic          run_ld;
        logic          rd_en;
        logic          mul_en;
        logic          div_start;
        logic          acc_en;
        logic          acc_clr;
        logic          out_load;
        logic          err_load;
        logic [1:0]    err_code;
        logic          last;
        logic [2:0]    op;
        logic [IW-1:0] i;
        logic [IW-1:0] j;
        logic [IW-1:0] k;
    } t_cmd;

    // datapath to controller status
    typedef struct packed {
        logic div_done;
    } t_sts;

endpackage

// ===== design/small_matrix_arithmetic_unit.sv =====
// Small matrix arithmetic unit: top level with configuration registers.
//
// Input channel (i_in_valid / o_in_ready / i_in): an item either writes one
// element of A or B (written as the item is accepted) or runs an operation. A run streams
// its result matrix in row-major order on the output channel
// (o_out_valid / i_out_ready / o_out), last set on the final element; a shape
// mismatch or a zero divisor gives one error element instead.
// One item is worked at a time; the input is not ready during a run.
// States per result element: read, multiply, accumulate, finish, output;
// a product repeats read, multiply, accumulate per inner term, and a divide
// runs the divider (one quotient bit per cycle) in place of the multiply.
// A run item with an error gives its element in the cycle after acceptance.
// A stalled receiver holds the element in the output register and the
// sequence waits; nothing is lost. Reset sets all dimensions to 6 and
// returns to idle; the matrix stores keep no reset value and must be written
// before they are read. Dimensions are to be written through i_cfg_* while
// idle; the user is bound by this, as the block itself does not enforce it.
module small_matrix_arithmetic_unit #(
    parameter int MAX_DIM   = 8,
    parameter int FRAC_BITS = 16
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  smau_pkg::t_in_item  i_in,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output smau_pkg::t_out_item o_out,
    input  logic                i_cfg_we,
    input  logic [1:0]          i_cfg_idx,
    input  logic [3:0]          i_cfg_data
);

    logic [3:0]     r_a_rows, r_a_cols, r_b_rows, r_b_cols;
    smau_pkg::t_cmd cmd;
    smau_pkg::t_sts sts;

    // dimension registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_rows <= 4'd6;
            r_a_cols <= 4'd6;
            r_b_rows <= 4'd6;
            r_b_cols <= 4'd6;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                smau_pkg::CFG_A_ROWS: r_a_rows <= i_cfg_data;
                smau_pkg::CFG_A_COLS: r_a_cols <= i_cfg_data;
                smau_pkg::CFG_B_ROWS: r_b_rows <= i_cfg_data;
                smau_pkg::CFG_B_COLS: r_b_cols <= i_cfg_data;
                default: ;
            endcase
        end
    end

    smau_ctrl #(
        .MAX_DIM (MAX_DIM)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in        (i_in),
        .i_out_ready (i_out_ready),
        .o_out_valid (o_out_valid),
        .i_a_rows    (r_a_rows),
        .i_a_cols    (r_a_cols),
        .i_b_rows    (r_b_rows),
        .i_b_cols    (r_b_cols),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    smau_dp #(
        .MAX_DIM   (MAX_DIM),
        .FRAC_BITS (FRAC_BITS)
    ) u_dp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (i_in),
        .i_cmd   (cmd),
        .o_sts   (sts),
        .o_out   (o_out)
    );

    // no new item is taken while a result is on offer
    a_busy_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !o_in_ready)
        else $error("input ready while a result is pending");

    // error results are single, final and zero
    a_err_shape: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && ((o_out.status == smau_pkg::ST_SHAPE) ||
                        (o_out.status == smau_pkg::ST_DIVZ))
        |-> o_out.last && (o_out.result == '0))
        else $error("error result not final or not zero");

    // the final element of a run returns the block to idle
    a_last_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_ready && o_out.last |=> o_in_ready)
        else $error("not idle after the final result");

endmodule

// ===== design/smau_ctrl.sv =====
// Sequencing controller: walks result elements and inner-product terms.
module smau_ctrl #(
    parameter int MAX_DIM = 8
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_in_valid,
    output logic                         o_in_ready,
    input  smau_pkg::t_in_item           i_in,
    input  logic                         i_out_ready,
    output logic                         o_out_valid,
    input  logic [3:0]                   i_a_rows,
    input  logic [3:0]                   i_a_cols,
    input  logic [3:0]                   i_b_rows,
    input  logic [3:0]                   i_b_cols,
    input  smau_pkg::t_sts               i_sts,
    output smau_pkg::t_cmd               o_cmd
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_RD   = 3'd1;
    localparam logic [2:0] S_MUL  = 3'd2;
    localparam logic [2:0] S_DIV  = 3'd3;
    localparam logic [2:0] S_ACC  = 3'd4;
    localparam logic [2:0] S_FIN  = 3'd5;
    localparam logic [2:0] S_OUT  = 3'd6;

    // clamp a dimension register to 1..MAX_DIM
    function automatic logic [smau_pkg::NW-1:0] f_dim(input logic [3:0] r);
        logic [smau_pkg::NW-1:0] v;
        v = {1'b0, r};
        if (v == '0) begin
            f_dim = smau_pkg::NW'(1);
        end else if (v > smau_pkg::NW'(MAX_DIM)) begin
            f_dim = smau_pkg::NW'(MAX_DIM);
        end else begin
            f_dim = v;
        end
    endfunction

    logic [2:0]                 r_state, n_state;
    logic [2:0]                 r_op, n_op;
    logic [smau_pkg::NW-1:0]    r_rr, n_rr, r_rc, n_rc, r_ac, n_ac;
    logic [smau_pkg::IW-1:0]    r_i, n_i, r_j, n_j, r_k, n_k;
    logic                       r_last, n_last;
    logic [smau_pkg::NW-1:0]    ar, ac, br, bc;
    logic                       shape_err;

    assign ar = f_dim(i_a_rows);
    assign ac = f_dim(i_a_cols);
    assign br = f_dim(i_b_rows);
    assign bc = f_dim(i_b_cols);

    assign shape_err = ((i_in.op == smau_pkg::OP_PROD) && (ac != br)) ||
                       (((i_in.op == smau_pkg::OP_SUM) || (i_in.op == smau_pkg::OP_DIFF))
                        && ((ar != br) || (ac != bc)));

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = (r_state == S_OUT);

    // next state and commands
    always_comb begin
        n_state = r_state;
        n_op    = r_op;
        n_rr    = r_rr;
        n_rc    = r_rc;
        n_ac    = r_ac;
        n_i     = r_i;
        n_j     = r_j;
        n_k     = r_k;
        n_last  = r_last;
        o_cmd   = '0;
        o_cmd.op = r_op;
        o_cmd.i  = r_i;
        o_cmd.j  = r_j;
        o_cmd.k  = r_k;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    case (i_in.mode)
                        smau_pkg::MODE_WR_A: o_cmd.wr_a = 1'b1;
                        smau_pkg::MODE_WR_B: o_cmd.wr_b = 1'b1;
                        smau_pkg::MODE_RUN: begin
                            if (i_in.op <= smau_pkg::OP_TRANS) begin
                                o_cmd.run_ld = 1'b1;
                                n_op = i_in.op;
                                n_i  = '0;
                                n_j  = '0;
                                n_k  = '0;
                                n_ac = ac;
                                n_rr = (i_in.op == smau_pkg::OP_TRANS) ? ac : ar;
                                if (i_in.op == smau_pkg::OP_PROD) begin
                                    n_rc = bc;
                                end else if (i_in.op == smau_pkg::OP_TRANS) begin
                                    n_rc = ar;
                                end else begin
                                    n_rc = ac;
                                end
                                if (shape_err) begin
                                    o_cmd.err_load = 1'b1;
                                    o_cmd.err_code = smau_pkg::ST_SHAPE;
                                    n_last  = 1'b1;
                                    n_state = S_OUT;
                                end else if ((i_in.op == smau_pkg::OP_DIV) &&
                                             (i_in.value == '0)) begin
                                    o_cmd.err_load = 1'b1;
                                    o_cmd.err_code = smau_pkg::ST_DIVZ;
                                    n_last  = 1'b1;
                                    n_state = S_OUT;
                                end else begin
                                    n_state = S_RD;
                                end
                            end
                        end
                        default: ;
                    endcase
                end
            end
            S_RD: begin
                o_cmd.rd_en = 1'b1;
                n_state = S_MUL;
            end
            S_MUL: begin
                if (r_op == smau_pkg::OP_DIV) begin
                    o_cmd.div_start = 1'b1;
                    n_state = S_DIV;
                end else begin
                    o_cmd.mul_en = 1'b1;
                    n_state = S_ACC;
                end
            end
            S_DIV: begin
                if (i_sts.div_done) begin
                    n_state = S_ACC;
                end
            end
            S_ACC: begin
                o_cmd.acc_en  = 1'b1;
                o_cmd.acc_clr = (r_k == '0);
                if ((r_op == smau_pkg::OP_PROD) &&
                    (({1'b0, r_k} + smau_pkg::NW'(1)) < r_ac)) begin
                    n_k = r_k + smau_pkg::IW'(1);
                    n_state = S_RD;
                end else begin
                    n_state = S_FIN;
                end
            end
            S_FIN: begin
                o_cmd.out_load = 1'b1;
                o_cmd.last = (({1'b0, r_i} + smau_pkg::NW'(1)) == r_rr) &&
                             (({1'b0, r_j} + smau_pkg::NW'(1)) == r_rc);
                n_last  = o_cmd.last;
                n_state = S_OUT;
            end
            S_OUT: begin
                if (i_out_ready) begin
                    if (r_last) begin
                        n_state = S_IDLE;
                    end else begin
                        n_k = '0;
                        if (({1'b0, r_j} + smau_pkg::NW'(1)) == r_rc) begin
                            n_j = '0;
                            n_i = r_i + smau_pkg::IW'(1);
                        end else begin
                            n_j = r_j + smau_pkg::IW'(1);
                        end
                        n_state = S_RD;
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_last  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_last  <= n_last;
        end
        r_op <= n_op;
        r_rr <= n_rr;
        r_rc <= n_rc;
        r_ac <= n_ac;
        r_i  <= n_i;
        r_j  <= n_j;
        r_k  <= n_k;
    end

endmodule

// ===== design/smau_dp.sv =====
// Datapath: matrix stores, multiplier, divider, accumulator, result register.
module smau_dp #(
    parameter int MAX_DIM   = 8,
    parameter int FRAC_BITS = 16
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  smau_pkg::t_in_item  i_in,
    input  smau_pkg::t_cmd      i_cmd,
    output smau_pkg::t_sts      o_sts,
    output smau_pkg::t_out_item o_out
);

    localparam int DEPTH = MAX_DIM * MAX_DIM;
    localparam int AW    = $clog2(DEPTH);
    localparam int DVW   = 32 + FRAC_BITS;
    localparam int CW    = $clog2(DVW + 1);

    logic signed [31:0] mem_a [DEPTH];
    logic signed [31:0] mem_b [DEPTH];

    logic signed [31:0] r_a_q, r_b_q, r_scalar;
    logic signed [63:0] r_prod, r_acc, term;
    logic [AW-1:0]      wa, ra_a, ra_b;
    logic               wr_ok;
    logic [AW-1:0]      a_row, a_col, b_row, b_col;

    logic [DVW-1:0]     r_div_q;
    logic [32:0]        r_div_rem;
    logic [31:0]        r_div_d;
    logic               r_div_neg;
    logic [CW-1:0]      r_div_cnt;
    logic [32:0]        div_sh;
    logic               div_ge;
    logic [31:0]        a_mag, s_mag;

    // write address, ignored outside the store
    assign wr_ok = (32'(i_in.row_index) < MAX_DIM) && (32'(i_in.col_index) < MAX_DIM);
    assign wa    = AW'(i_in.row_index) * AW'(MAX_DIM) + AW'(i_in.col_index);

    // read addresses per operation
    always_comb begin
        a_row = AW'(i_cmd.i);
        a_col = AW'(i_cmd.j);
        b_row = AW'(i_cmd.i);
        b_col = AW'(i_cmd.j);
        case (i_cmd.op)
            smau_pkg::OP_PROD: begin
                a_col = AW'(i_cmd.k);
                b_row = AW'(i_cmd.k);
            end
            smau_pkg::OP_TRANS: begin
                a_row = AW'(i_cmd.j);
                a_col = AW'(i_cmd.i);
            end
            default: ;
        endcase
    end
    assign ra_a = a_row * AW'(MAX_DIM) + a_col;
    assign ra_b = b_row * AW'(MAX_DIM) + b_col;

    // stores with registered read
    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_a && wr_ok) mem_a[wa] <= i_in.value;
        if (i_cmd.wr_b && wr_ok) mem_b[wa] <= i_in.value;
        if (i_cmd.rd_en) begin
            r_a_q <= mem_a[ra_a];
            r_b_q <= mem_b[ra_b];
        end
        if (i_cmd.run_ld) r_scalar <= i_in.value;
    end

    // multiplier, registered
    always_ff @(posedge i_clk) begin
        if (i_cmd.mul_en) begin
            r_prod <= r_a_q * ((i_cmd.op == smau_pkg::OP_SCALE) ? r_scalar : r_b_q);
        end
    end

    // restoring divider, one quotient bit a cycle
    assign a_mag  = r_a_q[31] ? 32'(-r_a_q) : 32'(r_a_q);
    assign s_mag  = r_scalar[31] ? 32'(-r_scalar) : 32'(r_scalar);
    assign div_sh = {r_div_rem[31:0], r_div_q[DVW-1]};
    assign div_ge = (div_sh >= {1'b0, r_div_d});
    assign o_sts.div_done = (r_div_cnt == '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_div_cnt <= '0;
        end else if (i_cmd.div_start) begin
            r_div_cnt <= CW'(DVW);
        end else if (r_div_cnt != '0) begin
            r_div_cnt <= r_div_cnt - CW'(1);
        end
        if (i_cmd.div_start) begin
            r_div_q   <= {a_mag, {FRAC_BITS{1'b0}}};
            r_div_rem <= '0;
            r_div_d   <= s_mag;
            r_div_neg <= r_a_q[31] ^ r_scalar[31];
        end else if (r_div_cnt != '0) begin
            r_div_rem <= div_ge ? (div_sh - {1'b0, r_div_d}) : div_sh;
            r_div_q   <= {r_div_q[DVW-2:0], div_ge};
        end
    end

    // accumulator term per operation
    always_comb begin
        case (i_cmd.op)
            smau_pkg::OP_PROD, smau_pkg::OP_SCALE: term = r_prod >>> FRAC_BITS;
            smau_pkg::OP_SUM:   term = 64'(r_a_q) + 64'(r_b_q);
            smau_pkg::OP_DIFF:  term = 64'(r_a_q) - 64'(r_b_q);
            smau_pkg::OP_TRANS: term = 64'(r_a_q);
            smau_pkg::OP_DIV:   term = r_div_neg ? -$signed(64'(r_div_q))
                                                 : $signed(64'(r_div_q));
            default:            term = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.acc_en) begin
            r_acc <= (i_cmd.acc_clr ? 64'sd0 : r_acc) + term;
        end
    end

    // result register with saturation
    always_ff @(posedge i_clk) begin
        if (i_cmd.err_load) begin
            o_out.out_row <= '0;
            o_out.out_col <= '0;
            o_out.result  <= '0;
            o_out.last    <= 1'b1;
            o_out.status  <= i_cmd.err_code;
        end else if (i_cmd.out_load) begin
            o_out.out_row <= i_cmd.i[2:0];
            o_out.out_col <= i_cmd.j[2:0];
            o_out.last    <= i_cmd.last;
            if ((r_acc[63:31] == '0) || (r_acc[63:31] == '1)) begin
                o_out.result <= r_acc[31:0];
                o_out.status <= smau_pkg::ST_OK;
            end else begin
                o_out.result <= r_acc[63] ? 32'sh8000_0000 : 32'sh7fff_ffff;
                o_out.status <= smau_pkg::ST_SAT;
            end
        end
    end

endmodule
